// ----- design/epr_pkg.sv -----
// Eye pixel renderer package: scene constants, register codes, coverage flags.
// No dependencies; imported by epr_pixel_if, epr_color_if, epr_cover and eye_pixel_renderer.

package epr_pkg;

  localparam int EprWidth  = 160;
  localparam int EprHeight = 160;

  localparam int CoordW  = 8;
  localparam int OffsetW = 6;
  localparam int LidW    = 7;
  localparam int CfgW    = 7;
  localparam int ColorW  = 16;

  typedef enum logic [1:0] {
    CfgIrisX = 2'd0,
    CfgIrisY = 2'd1,
    CfgLid   = 2'd2
  } epr_cfg_e;

  localparam logic [ColorW-1:0] ColBlack     = 16'h0000;
  localparam logic [ColorW-1:0] ColWhite     = 16'hFFFF;
  localparam logic [ColorW-1:0] ColIrisOuter = 16'h067F;
  localparam logic [ColorW-1:0] ColIrisMid   = 16'h04FC;
  localparam logic [ColorW-1:0] ColIrisInner = 16'h0255;

  // circle geometry, signed 10-bit coordinates, squared radii
  localparam logic signed [9:0] EyeCenter = 10'sd80;
  localparam logic signed [9:0] Glint1Dx  = -10'sd10;
  localparam logic signed [9:0] Glint1Dy  = -10'sd11;
  localparam logic signed [9:0] Glint2Dx  = 10'sd9;
  localparam logic signed [9:0] Glint2Dy  = 10'sd8;
  localparam logic [12:0] BallR2   = 13'd5476;
  localparam logic [12:0] OuterR2  = 13'd1444;
  localparam logic [12:0] MidR2    = 13'd961;
  localparam logic [12:0] InnerR2  = 13'd576;
  localparam logic [12:0] PupilR2  = 13'd324;
  localparam logic [12:0] Glint1R2 = 13'd49;
  localparam logic [12:0] Glint2R2 = 13'd9;

  // lid inset k = floor(5*d/41), d = 82 - row; k >= j+1 once d >= LidStep[j]
  localparam logic [7:0] LidMid = 8'd82;
  localparam int LidSteps = 10;
  localparam logic [6:0] LidStep [LidSteps] = '{
    7'd9, 7'd17, 7'd25, 7'd33, 7'd41, 7'd50, 7'd58, 7'd66, 7'd74, 7'd82
  };

  typedef struct packed {
    logic frame;
    logic ball;
    logic ring_outer;
    logic ring_mid;
    logic ring_inner;
    logic pupil;
    logic glint;
    logic lid;
  } epr_flags_t;

endpackage

// ----- design/epr_pixel_if.sv -----
// Pixel coordinate channel: valid/ready with column and row.
// Uses epr_pkg for field widths.

interface epr_pixel_if
  import epr_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CoordW-1:0] column;
  logic [CoordW-1:0] row;

  modport source (output valid, output column, output row, input ready);
  modport sink   (input valid, input column, input row, output ready);
endinterface

// ----- design/epr_color_if.sv -----
// Pixel color channel: valid/ready with an RGB565 value.
// Uses epr_pkg for field widths.

interface epr_color_if
  import epr_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [ColorW-1:0] pixel_color;

  modport source (output valid, output pixel_color, input ready);
  modport sink   (input valid, input pixel_color, output ready);
endinterface

// ----- design/epr_cover.sv -----
// Layer coverage for one pixel: circle tests and eyelid test, combinational.
// Depends on epr_pkg.

module epr_cover
  import epr_pkg::*;
#(
  parameter int WIDTH  = EprWidth,
  parameter int HEIGHT = EprHeight
) (
  input  logic [CoordW-1:0]         column_i,
  input  logic [CoordW-1:0]         row_i,
  input  logic signed [OffsetW-1:0] iris_x_i,
  input  logic signed [OffsetW-1:0] iris_y_i,
  input  logic [LidW-1:0]           lid_rows_i,
  output epr_flags_t                flags_o
);

  localparam logic [CoordW:0]   WidthW = (CoordW+1)'(WIDTH);
  localparam logic [CoordW:0]   HeightW = (CoordW+1)'(HEIGHT);
  localparam logic [CoordW-1:0] RowMax = CoordW'(HEIGHT - 1);

  function automatic logic hit(input logic [CoordW-1:0] px, input logic [CoordW-1:0] py,
                               input logic signed [9:0] cx, input logic signed [9:0] cy,
                               input logic [12:0] r2);
    logic signed [9:0] dx;
    logic signed [9:0] dy;
    logic signed [19:0] sx;
    logic signed [19:0] sy;
    logic [19:0] sq;
    dx = $signed({2'b00, px}) - cx;
    dy = $signed({2'b00, py}) - cy;
    sx = 20'(dx) * 20'(dx);
    sy = 20'(dy) * 20'(dy);
    sq = $unsigned(sx) + $unsigned(sy);
    return sq <= {7'd0, r2};
  endfunction

  function automatic logic lid_hit(input logic [CoordW-1:0] t, input logic [CoordW-1:0] px,
                                   input logic [LidW-1:0] lid);
    logic [6:0] span;
    logic [3:0] k;
    logic       res;
    span = 7'(LidMid - t);
    k = '0;
    for (int j = 0; j < LidSteps; j++) begin
      k = k + 4'(span >= LidStep[j]);
    end
    if (t >= {1'b0, lid}) begin
      res = 1'b0;
    end else if (t > LidMid) begin
      res = 1'b1;
    end else begin
      res = (px >= {4'd0, k}) && (({1'b0, px} + {5'd0, k}) < WidthW);
    end
    return res;
  endfunction

  logic signed [9:0] ix;
  logic signed [9:0] iy;
  logic [CoordW-1:0] mirror_row;

  assign ix = EyeCenter + {{(10-OffsetW){iris_x_i[OffsetW-1]}}, iris_x_i};
  assign iy = EyeCenter + {{(10-OffsetW){iris_y_i[OffsetW-1]}}, iris_y_i};
  assign mirror_row = RowMax - row_i;

  always_comb begin
    flags_o.frame      = ({1'b0, column_i} < WidthW) && ({1'b0, row_i} < HeightW);
    flags_o.ball       = hit(column_i, row_i, EyeCenter, EyeCenter, BallR2);
    flags_o.ring_outer = hit(column_i, row_i, ix, iy, OuterR2);
    flags_o.ring_mid   = hit(column_i, row_i, ix, iy, MidR2);
    flags_o.ring_inner = hit(column_i, row_i, ix, iy, InnerR2);
    flags_o.pupil      = hit(column_i, row_i, ix, iy, PupilR2);
    flags_o.glint      = hit(column_i, row_i, ix + Glint1Dx, iy + Glint1Dy, Glint1R2) ||
                         hit(column_i, row_i, ix + Glint2Dx, iy + Glint2Dy, Glint2R2);
    flags_o.lid        = lid_hit(row_i, column_i, lid_rows_i) ||
                         lid_hit(mirror_row, column_i, lid_rows_i);
  end

endmodule

// ----- design/eye_pixel_renderer.sv -----
// Eye pixel renderer top level: config registers, three-stage pixel pipeline.
// Depends on epr_pkg, epr_pixel_if, epr_color_if and epr_cover.
//
//  channel  | dir | payload              | accepted when
//  pix_i    | in  | column, row (8b)     | pix_i.valid & pix_i.ready
//  color_o  | out | pixel_color (16b)    | color_o.valid & color_o.ready
//  cfg      | in  | idx 2b, data 7b      | cfg_we_i
//
// One pixel per clock unless color_o stalls; stages: input reg, coverage flags, color reg.
// Each stage takes a new item when it is empty or its item moves on, so a
// stalled output fills at most three stages before pix_i.ready drops.
// Reset clears stage valids and the iris offsets and lid count to zero.

module eye_pixel_renderer
  import epr_pkg::*;
#(
  parameter int WIDTH  = EprWidth,
  parameter int HEIGHT = EprHeight
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [CfgW-1:0]   cfg_data_i,
  epr_pixel_if.sink         pix_i,
  epr_color_if.source       color_o
);

  logic signed [OffsetW-1:0] iris_x_q;
  logic signed [OffsetW-1:0] iris_y_q;
  logic [LidW-1:0]           lid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iris_x_q <= '0;
      iris_y_q <= '0;
      lid_q    <= '0;
    end else if (cfg_we_i) begin
      case (epr_cfg_e'(cfg_idx_i))
        CfgIrisX: iris_x_q <= cfg_data_i[OffsetW-1:0];
        CfgIrisY: iris_y_q <= cfg_data_i[OffsetW-1:0];
        CfgLid:   lid_q    <= cfg_data_i[LidW-1:0];
        default: ;
      endcase
    end
  end

  logic              v1_q, v2_q, v3_q;
  logic              rdy1, rdy2, rdy3;
  logic [CoordW-1:0] col_q, row_q;
  epr_flags_t        flags_d, flags_q;
  logic [ColorW-1:0] color_d, color_q;

  assign rdy3 = !v3_q || color_o.ready;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign pix_i.ready       = rdy1;
  assign color_o.valid     = v3_q;
  assign color_o.pixel_color = color_q;

  epr_cover #(
    .WIDTH  (WIDTH),
    .HEIGHT (HEIGHT)
  ) u_cover (
    .column_i   (col_q),
    .row_i      (row_q),
    .iris_x_i   (iris_x_q),
    .iris_y_i   (iris_y_q),
    .lid_rows_i (lid_q),
    .flags_o    (flags_d)
  );

  always_comb begin
    if (!flags_q.frame || flags_q.lid) begin
      color_d = ColBlack;
    end else if (flags_q.glint) begin
      color_d = ColWhite;
    end else if (flags_q.pupil) begin
      color_d = ColBlack;
    end else if (flags_q.ring_inner) begin
      color_d = ColIrisInner;
    end else if (flags_q.ring_mid) begin
      color_d = ColIrisMid;
    end else if (flags_q.ring_outer) begin
      color_d = ColIrisOuter;
    end else if (flags_q.ball) begin
      color_d = ColWhite;
    end else begin
      color_d = ColBlack;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= pix_i.valid;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && pix_i.valid) begin
      col_q <= pix_i.column;
      row_q <= pix_i.row;
    end
    if (rdy2 && v1_q) begin
      flags_q <= flags_d;
    end
    if (rdy3 && v2_q) begin
      color_q <= color_d;
    end
  end

  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    color_o.ready |-> pix_i.ready)
    else $error("input stalled while output drains");

  a_full_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && v2_q && v3_q && !color_o.ready) |-> !pix_i.ready)
    else $error("input accepted with full pipeline");

  a_offframe_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && rdy3 && !flags_q.frame) |=> (color_o.pixel_color == ColBlack))
    else $error("pixel outside frame not black");

  a_lid_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && rdy3 && flags_q.lid) |=> (color_o.pixel_color == ColBlack))
    else $error("lid pixel not black");

endmodule
